// ----- design/spq_pkg.sv -----
// shared types and constants for the stable priority queue
// no dependencies; imported by spq_cmp and stable_priority_queue
`default_nettype none

package spq_pkg;

	// default sizes, handed down through the top level parameters
	localparam int QUEUE_DEPTH_DEF   = 16;
	localparam int PRIORITY_BITS_DEF = 8;
	localparam int ID_BITS_DEF       = 16;

	// action codes of an input beat
	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_POP    = 2'd1,
		ACT_REMOVE = 2'd2
	} action_t;

	// status codes of a result beat
	typedef enum logic [1:0] {
		STAT_DONE = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_RD,
		S_INS_EV,
		S_SCAN_RD,
		S_SCAN_EV,
		S_SHF_RD,
		S_SHF_WR,
		S_DONE
	} state_t;

	// flags from the shared compare unit
	typedef struct packed {
		logic ge;
		logic eq;
	} cmp_flags_t;

endpackage

`default_nettype wire

// ----- design/stable_priority_queue.sv -----
// stable priority queue: sorted entry store in a ram, one slot per step.
// full, empty or invalid actions go straight to the result; insert compares slots from the tail down;
// pop and remove scan from the head, then move the later slots up; a remove miss scans every slot.
// one beat at a time: a new beat is taken only while idle; a stalled result holds the next.
// reset: asynchronous, active low; count 0, next id 1, no result pending; ram contents undefined.
// depends on spq_pkg, spq_ram, spq_cmp
`default_nettype none

module stable_priority_queue #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
	parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF,
	parameter int ID_BITS = spq_pkg::ID_BITS_DEF,
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [1:0]               action,
	input  wire logic [PRIORITY_BITS-1:0] priority_req,
	input  wire logic [ID_BITS-1:0]       target_id,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [1:0]                    status,
	output logic [ID_BITS-1:0]            entry_id,
	output logic [PRIORITY_BITS-1:0]      entry_priority,
	output logic [CW-1:0]                 occupancy
);
	import spq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int DW = ID_BITS + PRIORITY_BITS;

	state_t                   state_q, state_d;
	logic [CW-1:0]            k_q, k_d;
	logic [CW-1:0]            count_q, count_d;
	logic [ID_BITS-1:0]       next_id_q, next_id_d;
	action_t                  act_q;
	logic [PRIORITY_BITS-1:0] pri_q;
	logic [ID_BITS-1:0]       tid_q;
	status_t                  res_status_q, res_status_d;
	logic [ID_BITS-1:0]       res_id_q, res_id_d;
	logic [PRIORITY_BITS-1:0] res_pri_q, res_pri_d;

	logic                     out_valid_q;
	status_t                  status_q;
	logic [ID_BITS-1:0]       entry_id_q;
	logic [PRIORITY_BITS-1:0] entry_priority_q;
	logic [CW-1:0]            occupancy_q;

	logic                     in_beat;
	logic                     out_load;
	logic                     ram_we;
	logic [AW-1:0]            ram_waddr, ram_raddr;
	logic [DW-1:0]            ram_wdata, ram_rdata;
	logic [ID_BITS-1:0]       rd_id;
	logic [PRIORITY_BITS-1:0] rd_pri;
	cmp_flags_t               flags;

	assign in_stall = (state_q != S_IDLE);
	assign in_beat  = in_valid && !in_stall;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	assign rd_id  = ram_rdata[DW-1 -: ID_BITS];
	assign rd_pri = ram_rdata[PRIORITY_BITS-1:0];

	// entry store, head in slot 0
	spq_ram #(
		.WIDTH(DW),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// shared compare of the slot just read
	spq_cmp #(
		.PRIORITY_BITS(PRIORITY_BITS),
		.ID_BITS(ID_BITS)
	) u_cmp (
		.slot_pri(rd_pri),
		.req_pri (pri_q),
		.slot_id (rd_id),
		.req_id  (tid_q),
		.flags   (flags)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			next_id_q   <= {{(ID_BITS-1){1'b0}}, 1'b1};
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			next_id_q <= next_id_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working and result payload
	always_ff @(posedge clk) begin
		k_q          <= k_d;
		res_status_q <= res_status_d;
		res_id_q     <= res_id_d;
		res_pri_q    <= res_pri_d;
		if (in_beat) begin
			act_q <= action_t'(action);
			pri_q <= priority_req;
			tid_q <= target_id;
		end
		if (out_load) begin
			status_q         <= res_status_q;
			entry_id_q       <= res_id_q;
			entry_priority_q <= res_pri_q;
			occupancy_q      <= count_q;
		end
	end

	// sequencer: one slot read and one compare per step
	always_comb begin
		state_d      = state_q;
		k_d          = k_q;
		count_d      = count_q;
		next_id_d    = next_id_q;
		res_status_d = res_status_q;
		res_id_d     = res_id_q;
		res_pri_d    = res_pri_q;
		ram_we       = 1'b0;
		ram_waddr    = k_q[AW-1:0];
		ram_wdata    = {next_id_q, pri_q};
		ram_raddr    = k_q[AW-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					res_status_d = STAT_MISS;
					res_id_d     = '0;
					res_pri_d    = '0;
					k_d          = '0;
					unique case (action_t'(action))
						ACT_INSERT: begin
							if (count_q == CW'(QUEUE_DEPTH)) begin
								res_status_d = STAT_FULL;
								res_pri_d    = priority_req;
								state_d      = S_DONE;
							end else begin
								k_d     = count_q;
								state_d = S_INS_RD;
							end
						end
						ACT_POP, ACT_REMOVE: begin
							if (count_q == '0) begin
								state_d = S_DONE;
							end else begin
								state_d = S_SCAN_RD;
							end
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end

			// insert: walk down from the tail, moving lower priorities up
			S_INS_RD: begin
				if (k_q == '0) begin
					ram_we       = 1'b1;
					res_status_d = STAT_DONE;
					res_id_d     = next_id_q;
					res_pri_d    = pri_q;
					next_id_d    = next_id_q + ID_BITS'(1);
					count_d      = count_q + CW'(1);
					state_d      = S_DONE;
				end else begin
					ram_raddr = AW'(k_q - CW'(1));
					state_d   = S_INS_EV;
				end
			end

			S_INS_EV: begin
				ram_we = 1'b1;
				if (flags.ge) begin
					res_status_d = STAT_DONE;
					res_id_d     = next_id_q;
					res_pri_d    = pri_q;
					next_id_d    = next_id_q + ID_BITS'(1);
					count_d      = count_q + CW'(1);
					state_d      = S_DONE;
				end else begin
					ram_wdata = ram_rdata;
					k_d       = k_q - CW'(1);
					state_d   = S_INS_RD;
				end
			end

			// pop takes the head, remove searches from the head
			S_SCAN_RD: begin
				state_d = S_SCAN_EV;
			end

			S_SCAN_EV: begin
				if (act_q == ACT_POP || flags.eq) begin
					res_status_d = STAT_DONE;
					res_id_d     = rd_id;
					res_pri_d    = rd_pri;
					state_d      = S_SHF_RD;
				end else if (k_q + CW'(1) == count_q) begin
					state_d = S_DONE;
				end else begin
					k_d     = k_q + CW'(1);
					state_d = S_SCAN_RD;
				end
			end

			// close the gap: slot k takes slot k+1 up to the tail
			S_SHF_RD: begin
				if (k_q + CW'(1) == count_q) begin
					count_d = count_q - CW'(1);
					state_d = S_DONE;
				end else begin
					ram_raddr = AW'(k_q + CW'(1));
					state_d   = S_SHF_WR;
				end
			end

			S_SHF_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				k_d       = k_q + CW'(1);
				state_d   = S_SHF_RD;
			end

			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign entry_id       = entry_id_q;
	assign entry_priority = entry_priority_q;
	assign occupancy      = occupancy_q;

`ifndef ASSERT_OFF
	// fill count never passes the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	// an accepted beat always starts the sequencer
	a_beat_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> state_q != S_IDLE)
		else $error("accepted beat left sequencer idle");

	// the store is written only while a beat is in work
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q != S_IDLE && state_q != S_DONE))
		else $error("ram write outside an action");

	// the count moves only when a result is about to be produced
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_d != count_q) |=> state_q == S_DONE)
		else $error("count changed without finishing an action");
`endif

endmodule

`default_nettype wire

// ----- design/spq_ram.sv -----
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none

module spq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- design/spq_cmp.sv -----
// shared compare unit: priority order and id match against a slot read
// depends on spq_pkg
`default_nettype none

module spq_cmp #(
	parameter int PRIORITY_BITS = 8,
	parameter int ID_BITS = 16
) (
	input  wire logic [PRIORITY_BITS-1:0] slot_pri,
	input  wire logic [PRIORITY_BITS-1:0] req_pri,
	input  wire logic [ID_BITS-1:0]       slot_id,
	input  wire logic [ID_BITS-1:0]       req_id,
	output spq_pkg::cmp_flags_t           flags
);
	import spq_pkg::*;

	// slot stays ahead of the new entry when its priority is not lower
	assign flags.ge = (slot_pri >= req_pri);
	assign flags.eq = (slot_id == req_id);

endmodule

`default_nettype wire
